>>> rtl/core/triangle_rasterizer_depth_test_defines.svh
// Assertion helpers shared by the rasterizer RTL.
`ifndef TRIANGLE_RASTERIZER_DEPTH_TEST_DEFINES_SVH
`define TRIANGLE_RASTERIZER_DEPTH_TEST_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define TRD_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define TRD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/trd_pkg.sv
`default_nettype none

package trd_pkg;

  localparam int MAX_WIDTH  = 128;
  localparam int MAX_HEIGHT = 128;
  localparam int STORE_SIZE = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W     = $clog2(STORE_SIZE);

  localparam int CMD_W   = 2;
  localparam int COORD_W = 16;
  localparam int DEPTH_W = 24;
  localparam int COLOR_W = 24;
  localparam int COUNT_W = 15;
  localparam int CFG_W   = 8;

  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DRAW   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  // The area limit of 0.00001 in units of 2^-24.
  localparam int AREA_LIMIT = 167;

endpackage

`default_nettype wire

>>> rtl/core/triangle_rasterizer_depth_test.sv
// Flat-shaded triangle rasterizer with a 128 x 128 colour and depth store. A command is taken
// when start is high and busy is low; its single result appears for exactly one cycle with done
// high and must be captured then, as the receiver cannot hold it off. A clear writes one store
// entry per cycle. A draw runs a setup, then for each pixel of the clamped bounding box tests
// whether the pixel centre is inside the triangle and, if so, forms its weights and depth: one
// shared 26 x 26 multiplier evaluates the edge functions and the depth sum, and one radix-2
// divider forms the first two barycentric weights; the third is one minus their sum, or zero.
// The stores are not initialised at reset, so issue a clear before the first draw or read.
`default_nettype none
`include "triangle_rasterizer_depth_test_defines.svh"

module triangle_rasterizer_depth_test (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic [trd_pkg::CMD_W-1:0]       command,
  input  wire logic signed [trd_pkg::COORD_W-1:0] vertex_a_x,
  input  wire logic signed [trd_pkg::COORD_W-1:0] vertex_a_y,
  input  wire logic [trd_pkg::DEPTH_W-1:0]     vertex_a_depth,
  input  wire logic signed [trd_pkg::COORD_W-1:0] vertex_b_x,
  input  wire logic signed [trd_pkg::COORD_W-1:0] vertex_b_y,
  input  wire logic [trd_pkg::DEPTH_W-1:0]     vertex_b_depth,
  input  wire logic signed [trd_pkg::COORD_W-1:0] vertex_c_x,
  input  wire logic signed [trd_pkg::COORD_W-1:0] vertex_c_y,
  input  wire logic [trd_pkg::DEPTH_W-1:0]     vertex_c_depth,
  input  wire logic [trd_pkg::COLOR_W-1:0]     fill_color,
  input  wire logic [trd_pkg::ADDR_W-1:0]      pixel_index,
  output logic                                 done,
  output logic [trd_pkg::COLOR_W-1:0]          pixel_color,
  output logic [trd_pkg::COUNT_W-1:0]          pixels_written,
  output logic                                 triangle_skipped,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic                            cfg_index,
  input  wire logic [trd_pkg::CFG_W-1:0]       cfg_data
);

  import trd_pkg::*;

  localparam logic [4:0] ST_IDLE = 5'd0;
  localparam logic [4:0] ST_CLR  = 5'd1;
  localparam logic [4:0] ST_RD0  = 5'd2;
  localparam logic [4:0] ST_RD1  = 5'd3;
  localparam logic [4:0] ST_AR0  = 5'd4;
  localparam logic [4:0] ST_AR1  = 5'd5;
  localparam logic [4:0] ST_AR2  = 5'd6;
  localparam logic [4:0] ST_MAP  = 5'd7;
  localparam logic [4:0] ST_S0   = 5'd8;
  localparam logic [4:0] ST_S1   = 5'd9;
  localparam logic [4:0] ST_S2   = 5'd10;
  localparam logic [4:0] ST_CHK  = 5'd11;
  localparam logic [4:0] ST_RB0  = 5'd12;
  localparam logic [4:0] ST_RB1  = 5'd13;
  localparam logic [4:0] ST_P0   = 5'd14;
  localparam logic [4:0] ST_P1   = 5'd15;
  localparam logic [4:0] ST_P2   = 5'd16;
  localparam logic [4:0] ST_P3   = 5'd17;
  localparam logic [4:0] ST_P4   = 5'd18;
  localparam logic [4:0] ST_P5   = 5'd19;
  localparam logic [4:0] ST_P6   = 5'd20;
  localparam logic [4:0] ST_DVA  = 5'd21;
  localparam logic [4:0] ST_DVB  = 5'd22;
  localparam logic [4:0] ST_Z0   = 5'd23;
  localparam logic [4:0] ST_Z1   = 5'd24;
  localparam logic [4:0] ST_Z2   = 5'd25;
  localparam logic [4:0] ST_Z3   = 5'd26;

  localparam logic [24:0] ONE_Q24 = 25'h1000000;

  function automatic logic signed [25:0] sx16(input logic signed [15:0] v);
    return {{10{v[15]}}, v};
  endfunction

  function automatic logic signed [25:0] sx24(input logic signed [23:0] v);
    return {{2{v[23]}}, v};
  endfunction

  function automatic logic signed [53:0] sx52(input logic signed [51:0] v);
    return {{2{v[51]}}, v};
  endfunction

  logic [4:0]               state;
  logic [CFG_W-1:0]         frame_width;
  logic [CFG_W-1:0]         frame_height;
  logic [CFG_W-1:0]         w_eff;
  logic [CFG_W-1:0]         h_eff;

  logic signed [15:0]       vx [3];
  logic signed [15:0]       vy [3];
  logic [23:0]              vz [3];
  logic [COLOR_W-1:0]       color_r;
  logic [ADDR_W-1:0]        pix_r;
  logic signed [23:0]       pos_x [3];
  logic signed [23:0]       pos_y [3];
  logic [2:0]               map_k;
  logic [2:0]               map_j;
  logic [1:0]               map_v;

  logic signed [25:0]       mul_a;
  logic signed [25:0]       mul_b;
  logic signed [51:0]       prod;
  logic signed [53:0]       acc;
  logic signed [53:0]       s_r;
  logic signed [53:0]       ea;
  logic signed [53:0]       eb;
  logic signed [53:0]       ec;
  logic signed [53:0]       diff_now;
  logic [53:0]              abs_s;
  logic [53:0]              nb_r;
  logic [53:0]              mag_a;
  logic [53:0]              mag_b;
  logic                     covered;

  logic [53:0]              div_rem;
  logic [23:0]              div_q;
  logic                     div_sat;
  logic [4:0]               div_cnt;
  logic [54:0]              div_shift;
  logic                     div_ge;
  logic [53:0]              div_rem_next;
  logic [23:0]              div_q_next;
  logic [24:0]              wa;
  logic [24:0]              wb;
  logic [24:0]              wc;

  logic signed [23:0]       qx;
  logic signed [23:0]       qy;
  logic signed [23:0]       min_x;
  logic signed [23:0]       max_x;
  logic signed [23:0]       min_y;
  logic signed [23:0]       max_y;
  logic signed [24:0]       ceil_x;
  logic signed [24:0]       ceil_y;
  logic signed [11:0]       fl_x;
  logic signed [11:0]       fl_y;
  logic signed [11:0]       cl_x;
  logic signed [11:0]       cl_y;
  logic signed [11:0]       w_s;
  logic signed [11:0]       h_s;
  logic signed [11:0]       left_r;
  logic signed [11:0]       right_r;
  logic signed [11:0]       top_r;
  logic signed [11:0]       bottom_r;
  logic signed [11:0]       px;
  logic signed [11:0]       py;
  logic signed [11:0]       px_inc;
  logic signed [11:0]       py_inc;
  logic                     advance;

  logic [ADDR_W-1:0]        row_base;
  logic [ADDR_W-1:0]        idx;
  logic [ADDR_W-1:0]        clr_addr;
  logic [ADDR_W-1:0]        rd_addr;
  logic [COUNT_W-1:0]       count;
  logic [COUNT_W-1:0]       count_next;
  logic signed [53:0]       zsum;
  logic [25:0]              z;
  logic                     z_less;

  logic [COLOR_W-1:0]       color_mem [STORE_SIZE];
  logic [DEPTH_W-1:0]       depth_mem [STORE_SIZE];
  logic [COLOR_W-1:0]       cq;
  logic [DEPTH_W-1:0]       dq;
  logic                     mem_we;
  logic [ADDR_W-1:0]        mem_waddr;
  logic [COLOR_W-1:0]       color_wdata;
  logic [DEPTH_W-1:0]       depth_wdata;

  assign busy      = (state != ST_IDLE);
  assign cfg_ready = 1'b1;

  assign w_eff = (frame_width > CFG_W'(MAX_WIDTH)) ? CFG_W'(MAX_WIDTH) : frame_width;
  assign h_eff = (frame_height > CFG_W'(MAX_HEIGHT)) ? CFG_W'(MAX_HEIGHT) : frame_height;
  assign w_s   = {4'b0, w_eff};
  assign h_s   = {4'b0, h_eff};

  assign map_j = map_k - 3'd1;
  assign map_v = (map_k[2:1] == 2'd3) ? 2'd2 : map_k[2:1];

  // Pixel centre in units of 1/8192 pixel.
  assign qx = {3'b0, px[7:0], 13'h1000};
  assign qy = {3'b0, py[7:0], 13'h1000};

  assign idx     = row_base + ADDR_W'(px[7:0]);
  assign rd_addr = (state == ST_RD0) ? pix_r : idx;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_AR0: begin
        mul_a = sx16(vx[1]) - sx16(vx[0]);
        mul_b = sx16(vy[2]) - sx16(vy[0]);
      end
      ST_AR1: begin
        mul_a = sx16(vy[1]) - sx16(vy[0]);
        mul_b = sx16(vx[2]) - sx16(vx[0]);
      end
      ST_MAP: begin
        mul_a = map_k[0] ? sx16(vy[map_v]) : sx16(vx[map_v]);
        mul_b = {18'b0, h_eff};
      end
      ST_S0: begin
        mul_a = sx24(pos_x[1]) - sx24(pos_x[0]);
        mul_b = sx24(pos_y[2]) - sx24(pos_y[0]);
      end
      ST_S1: begin
        mul_a = sx24(pos_y[1]) - sx24(pos_y[0]);
        mul_b = sx24(pos_x[2]) - sx24(pos_x[0]);
      end
      ST_RB0: begin
        mul_a = {{14{top_r[11]}}, top_r};
        mul_b = {18'b0, w_eff};
      end
      ST_P0: begin
        mul_a = sx24(pos_x[1]) - sx24(qx);
        mul_b = sx24(pos_y[2]) - sx24(qy);
      end
      ST_P1: begin
        mul_a = sx24(pos_y[1]) - sx24(qy);
        mul_b = sx24(pos_x[2]) - sx24(qx);
      end
      ST_P2: begin
        mul_a = sx24(pos_x[2]) - sx24(qx);
        mul_b = sx24(pos_y[0]) - sx24(qy);
      end
      ST_P3: begin
        mul_a = sx24(pos_y[2]) - sx24(qy);
        mul_b = sx24(pos_x[0]) - sx24(qx);
      end
      ST_Z0: begin
        mul_a = {1'b0, wa};
        mul_b = {2'b0, vz[0]};
      end
      ST_Z1: begin
        mul_a = {1'b0, wb};
        mul_b = {2'b0, vz[1]};
      end
      ST_Z2: begin
        mul_a = {1'b0, wc};
        mul_b = {2'b0, vz[2]};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    min_x = pos_x[0];
    max_x = pos_x[0];
    min_y = pos_y[0];
    max_y = pos_y[0];
    if (pos_x[1] < min_x) min_x = pos_x[1];
    if (pos_x[2] < min_x) min_x = pos_x[2];
    if (pos_x[1] > max_x) max_x = pos_x[1];
    if (pos_x[2] > max_x) max_x = pos_x[2];
    if (pos_y[1] < min_y) min_y = pos_y[1];
    if (pos_y[2] < min_y) min_y = pos_y[2];
    if (pos_y[1] > max_y) max_y = pos_y[1];
    if (pos_y[2] > max_y) max_y = pos_y[2];
  end

  // An arithmetic shift by 13 is the floor division; adding 8191 first gives the ceiling.
  assign fl_x   = {min_x[23], min_x[23:13]};
  assign fl_y   = {min_y[23], min_y[23:13]};
  assign ceil_x = {max_x[23], max_x} + 25'sd8191;
  assign ceil_y = {max_y[23], max_y} + 25'sd8191;
  assign cl_x   = $signed(ceil_x[24:13]);
  assign cl_y   = $signed(ceil_y[24:13]);

  assign diff_now = acc - sx52(prod);

  assign mag_a   = s_r[53] ? 54'(-ea) : 54'(ea);
  assign mag_b   = s_r[53] ? 54'(-eb) : 54'(eb);
  assign covered = s_r[53] ? (ea <= 0 && eb <= 0 && ec <= 0)
                           : (ea >= 0 && eb >= 0 && ec >= 0);

  assign div_shift    = {div_rem, 1'b0};
  assign div_ge       = div_shift >= {1'b0, abs_s};
  assign div_rem_next = div_ge ? 54'(div_shift - {1'b0, abs_s}) : div_shift[53:0];
  assign div_q_next   = {div_q[22:0], div_ge};

  assign zsum       = acc + sx52(prod);
  assign z          = zsum[49:24];
  assign z_less     = (z < {2'b0, dq});
  assign count_next = count + COUNT_W'((state == ST_Z3) && z_less);

  assign px_inc  = px + 12'sd1;
  assign py_inc  = py + 12'sd1;
  assign advance = ((state == ST_P6) && !covered) || (state == ST_Z3);

  always_comb begin
    mem_we      = 1'b0;
    mem_waddr   = idx;
    color_wdata = color_r;
    depth_wdata = z[23:0];
    if (state == ST_CLR) begin
      mem_we      = 1'b1;
      mem_waddr   = clr_addr;
      depth_wdata = '1;
    end else if (state == ST_Z3) begin
      mem_we = z_less;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      color_mem[mem_waddr] <= color_wdata;
    end
    cq <= color_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      depth_mem[mem_waddr] <= depth_wdata;
    end
    dq <= depth_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= CFG_W'(MAX_WIDTH);
      frame_height <= CFG_W'(MAX_HEIGHT);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default:          frame_width  <= frame_width;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (start) begin
            vx[0]   <= vertex_a_x;
            vy[0]   <= vertex_a_y;
            vz[0]   <= vertex_a_depth;
            vx[1]   <= vertex_b_x;
            vy[1]   <= vertex_b_y;
            vz[1]   <= vertex_b_depth;
            vx[2]   <= vertex_c_x;
            vy[2]   <= vertex_c_y;
            vz[2]   <= vertex_c_depth;
            color_r <= fill_color;
            pix_r   <= pixel_index;
            case (command)
              CMD_CLEAR: begin
                clr_addr <= '0;
                state    <= ST_CLR;
              end
              CMD_DRAW: state <= ST_AR0;
              CMD_READ: state <= ST_RD0;
              default: begin
                // The unused command code answers with all zeros at once.
                pixel_color      <= '0;
                pixels_written   <= '0;
                triangle_skipped <= 1'b0;
                done             <= 1'b1;
              end
            endcase
          end
        end
        ST_CLR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == '1) begin
            pixel_color      <= '0;
            pixels_written   <= '0;
            triangle_skipped <= 1'b0;
            done             <= 1'b1;
            state            <= ST_IDLE;
          end
        end
        ST_RD0: state <= ST_RD1;
        ST_RD1: begin
          pixel_color      <= cq;
          pixels_written   <= '0;
          triangle_skipped <= 1'b0;
          done             <= 1'b1;
          state            <= ST_IDLE;
        end
        ST_AR0: state <= ST_AR1;
        ST_AR1: begin
          acc   <= sx52(prod);
          state <= ST_AR2;
        end
        ST_AR2: begin
          if (diff_now <= AREA_LIMIT && diff_now >= -AREA_LIMIT) begin
            pixel_color      <= '0;
            pixels_written   <= '0;
            triangle_skipped <= 1'b1;
            done             <= 1'b1;
            state            <= ST_IDLE;
          end else begin
            map_k <= '0;
            state <= ST_MAP;
          end
        end
        ST_MAP: begin
          // Each step issues one vertex product and retires the previous one.
          if (map_k != 3'd0) begin
            if (!map_j[0]) begin
              pos_x[map_j[2:1]] <= prod[23:0] + {4'b0, w_eff, 12'b0};
            end else begin
              pos_y[map_j[2:1]] <= {4'b0, h_eff, 12'b0} - prod[23:0];
            end
          end
          map_k <= map_k + 3'd1;
          if (map_k == 3'd6) begin
            state <= ST_S0;
          end
        end
        ST_S0: state <= ST_S1;
        ST_S1: begin
          acc   <= sx52(prod);
          state <= ST_S2;
        end
        ST_S2: begin
          s_r      <= diff_now;
          left_r   <= (fl_x < 0) ? 12'sd0 : fl_x;
          top_r    <= (fl_y < 0) ? 12'sd0 : fl_y;
          right_r  <= (cl_x > w_s) ? w_s : cl_x;
          bottom_r <= (cl_y > h_s) ? h_s : cl_y;
          state    <= ST_CHK;
        end
        ST_CHK: begin
          abs_s <= s_r[53] ? 54'(-s_r) : 54'(s_r);
          px    <= left_r;
          py    <= top_r;
          count <= '0;
          if (s_r == 0 || left_r >= right_r || top_r >= bottom_r) begin
            pixel_color      <= '0;
            pixels_written   <= '0;
            triangle_skipped <= 1'b0;
            done             <= 1'b1;
            state            <= ST_IDLE;
          end else begin
            state <= ST_RB0;
          end
        end
        ST_RB0: state <= ST_RB1;
        ST_RB1: begin
          row_base <= prod[ADDR_W-1:0];
          state    <= ST_P0;
        end
        ST_P0: state <= ST_P1;
        ST_P1: begin
          acc   <= sx52(prod);
          state <= ST_P2;
        end
        ST_P2: begin
          ea    <= diff_now;
          state <= ST_P3;
        end
        ST_P3: begin
          acc   <= sx52(prod);
          state <= ST_P4;
        end
        ST_P4: begin
          eb    <= diff_now;
          state <= ST_P5;
        end
        ST_P5: begin
          ec    <= s_r - ea - eb;
          state <= ST_P6;
        end
        ST_P6: begin
          // A pixel outside the triangle is stepped over below.
          if (covered) begin
            div_rem <= mag_a;
            div_sat <= (mag_a >= abs_s);
            div_q   <= '0;
            div_cnt <= '0;
            nb_r    <= mag_b;
            state   <= ST_DVA;
          end
        end
        ST_DVA: begin
          div_rem <= div_rem_next;
          div_q   <= div_q_next;
          div_cnt <= div_cnt + 5'd1;
          if (div_cnt == 5'd23) begin
            wa      <= div_sat ? ONE_Q24 : {1'b0, div_q_next};
            div_rem <= nb_r;
            div_sat <= (nb_r >= abs_s);
            div_q   <= '0;
            div_cnt <= '0;
            state   <= ST_DVB;
          end
        end
        ST_DVB: begin
          div_rem <= div_rem_next;
          div_q   <= div_q_next;
          div_cnt <= div_cnt + 5'd1;
          if (div_cnt == 5'd23) begin
            wb    <= div_sat ? ONE_Q24 : {1'b0, div_q_next};
            state <= ST_Z0;
          end
        end
        ST_Z0: begin
          if (({1'b0, wa} + {1'b0, wb}) >= {1'b0, ONE_Q24}) begin
            wc <= '0;
          end else begin
            wc <= ONE_Q24 - wa - wb;
          end
          state <= ST_Z1;
        end
        ST_Z1: begin
          acc   <= sx52(prod);
          state <= ST_Z2;
        end
        ST_Z2: begin
          acc   <= zsum;
          state <= ST_Z3;
        end
        ST_Z3: begin
          count <= count_next;
        end
        default: state <= ST_IDLE;
      endcase

      // Step to the next pixel of the box, row by row, or finish the draw.
      if (advance) begin
        if (px_inc < right_r) begin
          px    <= px_inc;
          state <= ST_P0;
        end else if (py_inc < bottom_r) begin
          px       <= left_r;
          py       <= py_inc;
          row_base <= row_base + ADDR_W'(w_eff);
          state    <= ST_P0;
        end else begin
          pixel_color      <= '0;
          pixels_written   <= count_next;
          triangle_skipped <= 1'b0;
          done             <= 1'b1;
          state            <= ST_IDLE;
        end
      end
    end
  end

  `TRD_ASSERT_IMPL(a_done_when_idle, clk, rst, done, !busy, "result strobe while still busy")
  `TRD_ASSERT_NEXT(a_start_goes_busy, clk, rst, start && !busy && command != CMD_UNUSED, busy, "command not taken")
  `TRD_ASSERT_NEXT(a_idle_stays, clk, rst, !busy && !start, !busy && !done, "block woke without a command")
  `TRD_ASSERT_IMPL(a_skip_no_pixels, clk, rst, done && triangle_skipped, pixels_written == '0, "skipped triangle wrote pixels")

endmodule

`default_nettype wire

>>> bench/rasterizer_checker.sv
`timescale 1ns / 100ps

module rasterizer_checker
  import trd_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic                      busy,
  input  logic [CMD_W-1:0]          command,
  input  logic signed [COORD_W-1:0] vertex_a_x,
  input  logic signed [COORD_W-1:0] vertex_a_y,
  input  logic [DEPTH_W-1:0]        vertex_a_depth,
  input  logic signed [COORD_W-1:0] vertex_b_x,
  input  logic signed [COORD_W-1:0] vertex_b_y,
  input  logic [DEPTH_W-1:0]        vertex_b_depth,
  input  logic signed [COORD_W-1:0] vertex_c_x,
  input  logic signed [COORD_W-1:0] vertex_c_y,
  input  logic [DEPTH_W-1:0]        vertex_c_depth,
  input  logic [COLOR_W-1:0]        fill_color,
  input  logic [ADDR_W-1:0]         pixel_index,
  input  logic                      done,
  input  logic [COLOR_W-1:0]        pixel_color,
  input  logic [COUNT_W-1:0]        pixels_written,
  input  logic                      triangle_skipped,
  input  logic                      cfg_valid,
  input  logic                      cfg_ready,
  input  logic                      cfg_index,
  input  logic [CFG_W-1:0]          cfg_data,
  output int                        outstanding,
  output int                        errors
);

  typedef struct {
    logic [COLOR_W-1:0] colour;
    logic [COUNT_W-1:0] written;
    logic               skipped;
  } response_t;

  logic [COLOR_W-1:0] colour_mem [STORE_SIZE];
  logic [DEPTH_W-1:0] depth_mem [STORE_SIZE];
  int unsigned        width_reg;
  int unsigned        height_reg;
  response_t          response_q[$];

  function automatic longint floor_px(longint v);
    if (v >= 0) return v / 8192;
    return -((-v + 8191) / 8192);
  endfunction

  function automatic longint unsigned weight_q24(longint unsigned n, longint unsigned d);
    longint unsigned q;
    q = 0;
    if (n >= d) return 64'd1 << 24;
    for (int i = 0; i < 24; i++) begin
      n = n << 1;
      q = q << 1;
      if (n >= d) begin
        n = n - d;
        q = q | 1;
      end
    end
    return q;
  endfunction

  // Rasterises one triangle into the model stores and returns how many pixels won the depth test.
  function automatic int unsigned rasterise(longint ax, longint ay, longint bx, longint by,
                                            longint cx, longint cy, longint unsigned za,
                                            longint unsigned zb, longint unsigned zc,
                                            logic [COLOR_W-1:0] colour);
    longint w, h, xa, ya, xb, yb, xc, yc, s, sa, left, right, top, bottom;
    longint qx, qy, ea, eb, ec, idx;
    longint unsigned wa, wb, wc, z;
    int unsigned count;
    w = (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
    h = (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg;
    xa = ax * h + 4096 * w; ya = 4096 * h - ay * h;
    xb = bx * h + 4096 * w; yb = 4096 * h - by * h;
    xc = cx * h + 4096 * w; yc = 4096 * h - cy * h;
    s = (xb - xa) * (yc - ya) - (yb - ya) * (xc - xa);
    left   = floor_px((xa < xb) ? ((xa < xc) ? xa : xc) : ((xb < xc) ? xb : xc));
    right  = -floor_px(-((xa > xb) ? ((xa > xc) ? xa : xc) : ((xb > xc) ? xb : xc)));
    top    = floor_px((ya < yb) ? ((ya < yc) ? ya : yc) : ((yb < yc) ? yb : yc));
    bottom = -floor_px(-((ya > yb) ? ((ya > yc) ? ya : yc) : ((yb > yc) ? yb : yc)));
    count = 0;
    if (left < 0) left = 0;
    if (right > w) right = w;
    if (top < 0) top = 0;
    if (bottom > h) bottom = h;
    if (s == 0) return 0;
    for (longint py = top; py < bottom; py++) begin
      for (longint px = left; px < right; px++) begin
        qx = px * 8192 + 4096;
        qy = py * 8192 + 4096;
        ea = (xb - qx) * (yc - qy) - (yb - qy) * (xc - qx);
        eb = (xc - qx) * (ya - qy) - (yc - qy) * (xa - qx);
        ec = s - ea - eb;
        sa = s;
        if (sa < 0) begin
          sa = -sa; ea = -ea; eb = -eb; ec = -ec;
        end
        if (ea >= 0 && eb >= 0 && ec >= 0) begin
          wa = weight_q24(ea, sa);
          wb = weight_q24(eb, sa);
          wc = (wa + wb >= (64'd1 << 24)) ? 0 : (64'd1 << 24) - wa - wb;
          z = (wa * za + wb * zb + wc * zc) >> 24;
          idx = py * w + px;
          if (idx < STORE_SIZE && z[23:0] < depth_mem[idx]) begin
            depth_mem[idx]  = z[23:0];
            colour_mem[idx] = colour;
            count++;
          end
        end
      end
    end
    return count;
  endfunction

  always @(posedge clk) begin
    response_t exp_r, got_r;
    longint area;
    if (rst) begin
      width_reg  = 128;
      height_reg = 128;
      errors     = 0;
      response_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_FRAME_WIDTH) width_reg = cfg_data;
        else height_reg = cfg_data;
      end
      if (done) begin
        got_r = '{pixel_color, pixels_written, triangle_skipped};
        if (response_q.size() == 0) begin
          $display("%0t: result with nothing outstanding: colour %h written %0d skipped %0d",
                   $time, pixel_color, pixels_written, triangle_skipped);
          errors++;
        end else begin
          exp_r = response_q.pop_front();
          if (got_r.colour !== exp_r.colour) begin
            $display("%0t: pixel_color expected %h actual %h", $time, exp_r.colour, got_r.colour);
            errors++;
          end
          if (got_r.written !== exp_r.written) begin
            $display("%0t: pixels_written expected %0d actual %0d", $time, exp_r.written,
                     got_r.written);
            errors++;
          end
          if (got_r.skipped !== exp_r.skipped) begin
            $display("%0t: triangle_skipped expected %0d actual %0d", $time, exp_r.skipped,
                     got_r.skipped);
            errors++;
          end
        end
      end
      if (start && !busy) begin
        exp_r = '{'0, '0, 1'b0};
        case (command)
          CMD_CLEAR: begin
            for (int i = 0; i < STORE_SIZE; i++) begin
              colour_mem[i] = fill_color;
              depth_mem[i]  = '1;
            end
          end
          CMD_DRAW: begin
            area = (longint'(vertex_b_x) - vertex_a_x) * (longint'(vertex_c_y) - vertex_a_y)
                 - (longint'(vertex_b_y) - vertex_a_y) * (longint'(vertex_c_x) - vertex_a_x);
            if (area <= AREA_LIMIT && area >= -AREA_LIMIT) exp_r.skipped = 1'b1;
            else exp_r.written = COUNT_W'(rasterise(vertex_a_x, vertex_a_y, vertex_b_x,
                                                    vertex_b_y, vertex_c_x, vertex_c_y,
                                                    vertex_a_depth, vertex_b_depth,
                                                    vertex_c_depth, fill_color));
          end
          CMD_READ: exp_r.colour = colour_mem[pixel_index];
          default: ;
        endcase
        response_q.push_back(exp_r);
      end
    end
    outstanding <= response_q.size();
  end

endmodule

>>> bench/tb_triangle_rasterizer_depth_test.sv
`timescale 1ns / 100ps

module tb_triangle_rasterizer_depth_test;
  import trd_pkg::*;

  localparam int STALL_LIMIT = 200000;

  logic                      clk;
  logic                      rst;
  logic                      start;
  logic                      busy;
  logic [CMD_W-1:0]          command;
  logic signed [COORD_W-1:0] vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y;
  logic signed [COORD_W-1:0] vertex_c_x, vertex_c_y;
  logic [DEPTH_W-1:0]        vertex_a_depth, vertex_b_depth, vertex_c_depth;
  logic [COLOR_W-1:0]        fill_color;
  logic [ADDR_W-1:0]         pixel_index;
  logic                      done;
  logic [COLOR_W-1:0]        pixel_color;
  logic [COUNT_W-1:0]        pixels_written;
  logic                      triangle_skipped;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic                      cfg_index;
  logic [CFG_W-1:0]          cfg_data;
  int                        outstanding;
  int                        errors;
  int                        idle_pct;
  int                        quiet_cycles;
  int                        eff_w, eff_h;

  triangle_rasterizer_depth_test i_dut (.*);

  rasterizer_checker i_checker (.*);

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == STALL_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  task automatic send(logic [CMD_W-1:0] cmd, int ax, int ay, int bx, int by, int cx, int cy,
                      logic [DEPTH_W-1:0] za, logic [DEPTH_W-1:0] zb, logic [DEPTH_W-1:0] zc,
                      logic [COLOR_W-1:0] colour, logic [ADDR_W-1:0] idx);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start          <= 1'b1;
    command        <= cmd;
    vertex_a_x     <= COORD_W'(ax);
    vertex_a_y     <= COORD_W'(ay);
    vertex_b_x     <= COORD_W'(bx);
    vertex_b_y     <= COORD_W'(by);
    vertex_c_x     <= COORD_W'(cx);
    vertex_c_y     <= COORD_W'(cy);
    vertex_a_depth <= za;
    vertex_b_depth <= zb;
    vertex_c_depth <= zc;
    fill_color     <= colour;
    pixel_index    <= idx;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Waits for the block to go idle, then writes one frame size register.
  task automatic write_reg(logic index, logic [CFG_W-1:0] value);
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (index == REG_FRAME_WIDTH) eff_w = (value > MAX_WIDTH) ? MAX_WIDTH : value;
    else eff_h = (value > MAX_HEIGHT) ? MAX_HEIGHT : value;
  endtask

  function automatic int clamp16(int v);
    return (v > 32767) ? 32767 : ((v < -32768) ? -32768 : v);
  endfunction

  task automatic send_random_triangle();
    int ax, ay, spread;
    // Large frames get compact triangles so that the pixel loop stays short.
    spread = (eff_w > 16 || eff_h > 16) ? 400 : 40000;
    ax = $signed(16'($urandom));
    ay = $signed(16'($urandom));
    if (spread > 1000 && $urandom_range(1)) begin
      send(CMD_DRAW, ax, ay, $signed(16'($urandom)), $signed(16'($urandom)),
           $signed(16'($urandom)), $signed(16'($urandom)), DEPTH_W'($urandom),
           DEPTH_W'($urandom), DEPTH_W'($urandom), COLOR_W'($urandom), '0);
    end else begin
      send(CMD_DRAW, ax, ay,
           clamp16(ax + $urandom_range(2 * spread) - spread),
           clamp16(ay + $urandom_range(2 * spread) - spread),
           clamp16(ax + $urandom_range(2 * spread) - spread),
           clamp16(ay + $urandom_range(2 * spread) - spread),
           DEPTH_W'($urandom), DEPTH_W'($urandom), DEPTH_W'($urandom), COLOR_W'($urandom),
           '0);
    end
  endtask

  task automatic random_frame();
    int pick;
    pick = $urandom_range(9);
    write_reg(REG_FRAME_WIDTH, (pick == 0) ? 8'd255 : ((pick == 1) ? 8'd0 :
              CFG_W'($urandom_range(1, 16))));
    pick = $urandom_range(9);
    write_reg(REG_FRAME_HEIGHT, (pick == 0) ? 8'd128 : ((pick == 1) ? 8'd0 :
              CFG_W'($urandom_range(1, 16))));
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    command = CMD_CLEAR;
    {vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y, vertex_c_x, vertex_c_y} = '0;
    {vertex_a_depth, vertex_b_depth, vertex_c_depth} = '0;
    fill_color = '0;
    pixel_index = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_FRAME_WIDTH;
    cfg_data = '0;
    idle_pct = 0;
    eff_w = MAX_WIDTH;
    eff_h = MAX_HEIGHT;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: the stores hold nothing until the first clear.
    write_reg(REG_FRAME_WIDTH, 8'd8);
    write_reg(REG_FRAME_HEIGHT, 8'd8);
    send(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 24'h123456, '0);
    send(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 14'h3FFF);
    send(CMD_DRAW, -32768, -32768, 32767, -32768, 0, 32767, 24'hFFFFFF, 24'h000000,
         24'h800000, 24'hFFFFFF, '0);
    send(CMD_DRAW, -32768, -32768, 0, 32767, 32767, -32768, 0, 0, 0, 24'h0000FF, '0);
    send(CMD_DRAW, -32768, 32767, 32767, 32767, -32768, -32768, 24'hFFFFFE, 1, 2,
         24'h00FF00, '0);
    send(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 14'd27);
    send(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 14'd0);
    // Collinear, area just at the skip limit, and just past it.
    send(CMD_DRAW, -4096, -4096, 0, 0, 4096, 4096, 0, 0, 0, 24'hABCDEF, '0);
    send(CMD_DRAW, 0, 0, 1, 0, 0, AREA_LIMIT, 0, 0, 0, 24'hABCDEF, '0);
    send(CMD_DRAW, 0, 0, 1, 0, 0, AREA_LIMIT + 1, 0, 0, 0, 24'hABCDEF, '0);
    send(CMD_DRAW, 0, 0, 0, -AREA_LIMIT, 1, 0, 0, 0, 0, 24'hABCDEF, '0);
    send(CMD_UNUSED, 1, 1, 1, 1, 1, 1, 1, 1, 1, 24'hFFFFFF, 14'h3FFF);
    write_reg(REG_FRAME_WIDTH, 8'd0);
    send(CMD_DRAW, -20000, -20000, 20000, -20000, 0, 20000, 0, 0, 0, 24'h00AA00, '0);
    write_reg(REG_FRAME_WIDTH, 8'd1);
    write_reg(REG_FRAME_HEIGHT, 8'd0);
    send(CMD_DRAW, -20000, -20000, 20000, -20000, 0, 20000, 0, 0, 0, 24'h00AA00, '0);
    write_reg(REG_FRAME_HEIGHT, 8'd1);
    send(CMD_DRAW, -20000, -20000, 20000, -20000, 0, 20000, 0, 0, 0, 24'h00AA00, '0);
    send(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 14'd0);
    write_reg(REG_FRAME_WIDTH, 8'd255);
    write_reg(REG_FRAME_HEIGHT, 8'd200);
    send(CMD_DRAW, 100, 100, 600, -100, 300, 500, 24'h000100, 24'h700000, 24'h0A0000,
         24'hFF00FF, '0);
    send(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 14'd8192 + 14'd70);
    send(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 24'h000000, '0);

    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 13 : ((phase == 1) ? 81 : 0);
      random_frame();
      send(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0, COLOR_W'($urandom), '0);
      for (int n = 0; n < 27; n++) begin
        int pick;
        pick = $urandom_range(99);
        if (pick < 65) send_random_triangle();
        else if (pick < 90)
          send(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0,
               $urandom_range(1) ? ADDR_W'($urandom) :
               ADDR_W'($urandom_range(0, (eff_w * eff_h > 0) ? eff_w * eff_h - 1 : 0)));
        else if (pick < 93) send(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0, COLOR_W'($urandom), '0);
        else send(CMD_UNUSED, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                  DEPTH_W'($urandom), DEPTH_W'($urandom), DEPTH_W'($urandom),
                  COLOR_W'($urandom), ADDR_W'($urandom));
      end
    end

    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
